// File: src/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue
// used by spq_ctrl, spq_dp and stable_priority_queue; no dependencies
package spq_pkg;

   localparam int ENTRIES       = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int COUNT_BITS    = $clog2(ENTRIES + 1);
   localparam int INDEX_BITS    = $clog2(ENTRIES);

   typedef enum logic {
      FUNC_ENQUEUE = 1'b0,
      FUNC_DEQUEUE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] value_in;
      logic signed [15:0] priority_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value_out;
      logic signed [15:0] priority_out;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef logic signed [PRIORITY_BITS-1:0] prio_type;
   typedef logic [COUNT_BITS-1:0]           count_type;

endpackage

// File: src/spq_ctrl.sv
// spq_ctrl: request/response sequencing for the stable priority queue
// depends on spq_pkg; drives the command struct into spq_dp
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.execute = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/spq_dp.sv
// spq_dp: sorted shift-register cells, request register and response register
// depends on spq_pkg; commanded by spq_ctrl
module spq_dp (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd,
   input  spq_pkg::req_type req_data,
   output spq_pkg::rsp_type rsp_data
);

   localparam int N = spq_pkg::ENTRIES;

   spq_pkg::req_type   req_ff;
   spq_pkg::rsp_type   rsp_ff, rsp_in;
   spq_pkg::count_type count_ff, count_in;
   logic signed [31:0] value_ff [N];
   logic signed [31:0] value_in [N];
   spq_pkg::prio_type  prio_ff [N];
   spq_pkg::prio_type  prio_in [N];
   spq_pkg::prio_type  new_prio;
   logic [N-1:0]       before_new;
   logic               full, empty;

   assign new_prio = spq_pkg::prio_type'(req_ff.priority_in[spq_pkg::PRIORITY_BITS-1:0]);
   assign full     = (count_ff == spq_pkg::count_type'(N));
   assign empty    = (count_ff == '0);

   // cell stays ahead of the new entry when held and not of higher priority number
   always_comb begin
      for (int i = 0; i < N; i++) begin
         before_new[i] = (spq_pkg::count_type'(i) < count_ff) && (prio_ff[i] <= new_prio);
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         value_in[i] = value_ff[i];
         prio_in[i]  = prio_ff[i];
      end
      count_in            = count_ff;
      rsp_in              = rsp_ff;
      rsp_in.status       = spq_pkg::STATUS_OK;
      rsp_in.value_out    = '0;
      rsp_in.priority_out = '0;
      if (req_ff.func == spq_pkg::FUNC_ENQUEUE) begin
         if (full) begin
            rsp_in.status = spq_pkg::STATUS_OVERFLOW;
         end else begin
            for (int i = 0; i < N; i++) begin
               if (!before_new[i]) begin
                  if (i == 0 || before_new[(i == 0) ? 0 : i-1]) begin
                     value_in[i] = req_ff.value_in;
                     prio_in[i]  = new_prio;
                  end else begin
                     value_in[i] = value_ff[(i == 0) ? 0 : i-1];
                     prio_in[i]  = prio_ff[(i == 0) ? 0 : i-1];
                  end
               end
            end
            count_in = count_ff + spq_pkg::count_type'(1);
         end
      end else begin
         if (empty) begin
            rsp_in.status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            rsp_in.value_out    = value_ff[0];
            rsp_in.priority_out = 16'(prio_ff[0]);
            for (int i = 0; i < N - 1; i++) begin
               value_in[i] = value_ff[i+1];
               prio_in[i]  = prio_ff[i+1];
            end
            count_in = count_ff - spq_pkg::count_type'(1);
         end
      end
      rsp_in.occupancy = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < N; i++) begin
            value_ff[i] <= value_in[i];
            prio_ff[i]  <= prio_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: src/stable_priority_queue.sv
// stable_priority_queue: bounded sorted priority queue, top level
// instantiates spq_ctrl and spq_dp; types from spq_pkg
//
// usage:
//  - req channel (req_valid/req_ready/req_data) carries one request: enqueue a
//    value with a priority, or dequeue the front entry
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response per
//    request: status, dequeued value and priority, occupancy after the request
//  - lower priority number leaves first, equal priorities leave in arrival order
//  - a taken request waits in the request register, then is executed, which
//    registers the response; the next request is taken only after that, set by the
//    capture/execute sequence of the controller; all cells compare and shift at once
//  - a request is taken while the previous response still waits in the output
//    register; a stalled receiver holds the next request in execute until the
//    response register frees up
//  - reset empties the queue (occupancy 0), clears rsp_valid and sets req_ready
//  - dequeue when empty answers underflow, enqueue when full answers overflow
//    and drops the request
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.occupancy <= 5'(spq_pkg::ENTRIES)))
      else $error("occupancy above capacity");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != spq_pkg::STATUS_OK)
      |-> (rsp_data.value_out == '0 && rsp_data.priority_out == '0))
      else $error("error response carries data");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::STATUS_UNDERFLOW)
      |-> (rsp_data.occupancy == '0))
      else $error("underflow with entries held");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::STATUS_OVERFLOW)
      |-> (rsp_data.occupancy == 5'(spq_pkg::ENTRIES)))
      else $error("overflow while not full");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken during execute");
`endif

endmodule
